FILE: rtl/core/nmea_checksum_framer_checker_unit_macros.svh
// Assertion macros for the NMEA checksum framer and checker.
// Used only by the top level; clocked on aclk, disabled while aresetn is low.
`ifndef NMEA_CHECKSUM_FRAMER_CHECKER_UNIT_MACROS_SVH
`define NMEA_CHECKSUM_FRAMER_CHECKER_UNIT_MACROS_SVH

// Same-cycle implication.
`define NMEACS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("nmeacs assertion failed");

// Next-cycle implication.
`define NMEACS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("nmeacs assertion failed");

`endif

FILE: rtl/core/nmeacs_pkg.sv
// Shared types, constants and helpers of the NMEA checksum framer and checker.
// No dependencies; imported by every module of the block.
package nmeacs_pkg;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [3:0] NIB_MASK  = 4'hF;

    localparam logic [7:0] HEX_DIGITS [16] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
    };

    typedef enum logic [2:0] {
        PH_START = 3'd0,
        PH_BODY  = 3'd1,
        PH_STAR  = 3'd2,
        PH_HI    = 3'd3,
        PH_LO    = 3'd4,
        PH_DROP  = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        OP_CHAR      = 2'd0,
        OP_CHAR_TAIL = 2'd1,
        OP_TAIL      = 2'd2,
        OP_VERDICT   = 2'd3
    } op_t;

    // Tail positions.
    localparam logic [2:0] TP_STAR = 3'd0;
    localparam logic [2:0] TP_HI   = 3'd1;
    localparam logic [2:0] TP_LO   = 3'd2;
    localparam logic [2:0] TP_CR   = 3'd3;
    localparam logic [2:0] TP_LF   = 3'd4;

    typedef struct packed {
        op_t        op;
        logic [7:0] ch;
        logic [7:0] sum;
        logic       ok;
    } cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_stat_t;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        return HEX_DIGITS[nib & NIB_MASK];
    endfunction

    function automatic logic [7:0] tail_char(input logic [2:0] pos, input logic [7:0] sum);
        logic [7:0] c;
        c = CH_LF;
        case (pos)
            TP_STAR: c = CH_STAR;
            TP_HI:   c = hex_char(sum[7:4]);
            TP_LO:   c = hex_char(sum[3:0]);
            TP_CR:   c = CH_CR;
            default: c = CH_LF;
        endcase
        return c;
    endfunction

endpackage

FILE: rtl/core/nmea_checksum_framer_checker_unit.sv
// NMEA 0183 checksum framer and checker, top level.
// Ties nmeacs_front, nmeacs_queue and nmeacs_back together; uses nmeacs_pkg
// and the assertion macros header.
//
// Usage: sentence characters arrive one per transaction on the s_ channel,
// s_tdata[7:0] holding the character and s_tlast marking the last one.
// The cfg channel writes the one-bit mode (0 check, 1 generate); it is always
// ready, and a write abandons any line in progress. Write it only when idle.
// In generate mode each character up to '*' or the line end leaves on the
// m_ channel, followed by '*', two uppercase hex digits, CR and LF. In check
// mode the line end gives one verdict transaction with m_tuser high and the
// verdict in m_tdata[8]. m_tlast marks the last transaction caused by an input.
// An input character is registered in the command queue and then in the output
// register of the back end before its result leaves on the m_ channel.
// The front end takes one character per cycle while the command queue is not
// full; a sentence's tail adds five output transactions from one command. The
// four-entry command queue absorbs that burst and decouples the two sides.
// Reset (aresetn low, synchronous) clears mode to check, the line state, the
// queue and the output valid flag. When the receiver drops m_tready the output
// holds, the queue fills, and s_tready falls once the queue is full.
`include "nmea_checksum_framer_checker_unit_macros.svh"

module nmea_checksum_framer_checker_unit
    import nmeacs_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration write channel: mode register.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data,
    // Input stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_char
    input  logic        s_tlast,   // line_end
    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] out_char, [8] line_valid, [15:9] zero
    output logic        m_tlast,   // run_last
    output logic        m_tuser    // [0] result_kind
);

    logic       push, pop;
    cmd_t       push_cmd, head;
    q_stat_t    q_stat;
    logic [7:0] out_char;
    logic       line_valid;

    // Mode writes are taken at once.
    assign cfg_ready = 1'b1;

    nmeacs_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_valid(cfg_valid),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_char   (s_tdata),
        .s_last   (s_tlast),
        .q_stat   (q_stat),
        .s_ready  (s_tready),
        .push     (push),
        .push_cmd (push_cmd)
    );

    nmeacs_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .push_cmd(push_cmd),
        .pop     (pop),
        .head    (head),
        .stat    (q_stat)
    );

    nmeacs_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .head        (head),
        .q_stat      (q_stat),
        .pop         (pop),
        .m_ready     (m_tready),
        .m_valid     (m_tvalid),
        .m_char      (out_char),
        .m_last      (m_tlast),
        .m_line_valid(line_valid),
        .m_kind      (m_tuser)
    );

    assign m_tdata = {7'b0, line_valid, out_char};

    // The front end never pushes into a full queue, and the back end never pops an empty one.
    `NMEACS_ASSERT_IMP(a_no_overflow, push, !q_stat.full)
    `NMEACS_ASSERT_IMP(a_no_underflow, pop, !q_stat.empty)
    // A verdict carries no character and always closes its input's results.
    `NMEACS_ASSERT_IMP(a_verdict_shape, m_tvalid && m_tuser, m_tlast && (m_tdata[7:0] == 8'h00))
    // A character result never carries a verdict.
    `NMEACS_ASSERT_IMP(a_char_no_verdict, m_tvalid && !m_tuser, !m_tdata[8])

endmodule

FILE: rtl/core/nmeacs_front.sv
// Front end: holds the mode register and the line state, classifies each
// character and pushes at most one command per character. Depends on nmeacs_pkg.
module nmeacs_front
    import nmeacs_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_valid,
    input  logic       cfg_data,
    input  logic       s_tvalid,
    input  logic [7:0] s_char,
    input  logic       s_last,
    input  q_stat_t    q_stat,
    output logic       s_ready,
    output logic       push,
    output cmd_t       push_cmd
);

    logic       mode_reg;
    phase_t     phase_reg, phase_next;
    logic [7:0] xor_reg, xor_next;
    logic       mism_reg, mism_next;
    logic       accept;

    assign s_ready = !q_stat.full;
    assign accept  = s_tvalid && s_ready;

    always_comb begin
        phase_next    = phase_reg;
        xor_next      = xor_reg;
        mism_next     = mism_reg;
        push          = 1'b0;
        push_cmd.op   = OP_CHAR;
        push_cmd.ch   = s_char;
        push_cmd.sum  = xor_reg;
        push_cmd.ok   = 1'b0;
        if (mode_reg) begin
            case (phase_reg)
                PH_START: begin
                    push       = accept;
                    push_cmd.op = s_last ? OP_CHAR_TAIL : OP_CHAR;
                    phase_next = PH_BODY;
                end
                PH_BODY: begin
                    push = accept;
                    if (s_char == CH_STAR) begin
                        push_cmd.op = OP_TAIL;
                        phase_next  = PH_DROP;
                    end else begin
                        xor_next     = xor_reg ^ s_char;
                        push_cmd.sum = xor_reg ^ s_char;
                        push_cmd.op  = s_last ? OP_CHAR_TAIL : OP_CHAR;
                    end
                end
                default: ;
            endcase
        end else begin
            case (phase_reg)
                PH_START: begin
                    if (s_char != CH_DOLLAR) mism_next = 1'b1;
                    phase_next = PH_BODY;
                end
                PH_BODY: begin
                    if (s_char == CH_STAR) phase_next = PH_STAR;
                    else                   xor_next   = xor_reg ^ s_char;
                end
                PH_STAR: begin
                    if (s_char != hex_char(xor_reg[7:4])) mism_next = 1'b1;
                    phase_next = PH_HI;
                end
                PH_HI: begin
                    if (s_char != hex_char(xor_reg[3:0])) mism_next = 1'b1;
                    phase_next = PH_LO;
                end
                default: begin
                    mism_next  = 1'b1;
                    phase_next = PH_DROP;
                end
            endcase
            push        = accept && s_last;
            push_cmd.op = OP_VERDICT;
            push_cmd.ch = 8'h00;
            push_cmd.ok = !mism_next && (phase_next == PH_LO);
        end
        if (s_last) begin
            phase_next = PH_START;
            xor_next   = 8'h00;
            mism_next  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= 1'b0;
            phase_reg <= PH_START;
            xor_reg   <= 8'h00;
            mism_reg  <= 1'b0;
        end else if (cfg_valid) begin
            mode_reg  <= cfg_data;
            phase_reg <= PH_START;
            xor_reg   <= 8'h00;
            mism_reg  <= 1'b0;
        end else if (accept) begin
            phase_reg <= phase_next;
            xor_reg   <= xor_next;
            mism_reg  <= mism_next;
        end
    end

endmodule

FILE: rtl/core/nmeacs_queue.sv
// Short command queue between the front end and the back end.
// Depends on nmeacs_pkg for cmd_t, q_stat_t and the depth constants.
module nmeacs_queue
    import nmeacs_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  cmd_t    push_cmd,
    input  logic    pop,
    output cmd_t    head,
    output q_stat_t stat
);

    cmd_t              mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign head       = mem[rd_ptr_reg];
    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == QCNT_W'(QDEPTH));

    always_comb begin
        count_next = count_reg;
        if (push && !pop)      count_next = count_reg + 1'b1;
        else if (pop && !push) count_next = count_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

endmodule

FILE: rtl/core/nmeacs_back.sv
// Back end: expands queued commands into result transactions and holds
// the output register. Depends on nmeacs_pkg.
module nmeacs_back
    import nmeacs_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  cmd_t       head,
    input  q_stat_t    q_stat,
    output logic       pop,
    input  logic       m_ready,
    output logic       m_valid,
    output logic [7:0] m_char,
    output logic       m_last,
    output logic       m_line_valid,
    output logic       m_kind
);

    logic [2:0] step_reg;
    logic [2:0] tail_pos;
    logic [7:0] res_char;
    logic       res_last, res_valid, res_kind, res_final;
    logic       advance;

    logic       m_valid_reg;
    logic [7:0] m_char_reg;
    logic       m_last_reg, m_line_valid_reg, m_kind_reg;

    assign tail_pos = (head.op == OP_CHAR_TAIL) ? (step_reg - 3'd1) : step_reg;

    always_comb begin
        res_char  = head.ch;
        res_last  = 1'b1;
        res_valid = 1'b0;
        res_kind  = 1'b0;
        res_final = 1'b1;
        case (head.op)
            OP_CHAR: ;
            OP_VERDICT: begin
                res_char  = 8'h00;
                res_valid = head.ok;
                res_kind  = 1'b1;
            end
            default: begin
                if (head.op == OP_CHAR_TAIL && step_reg == 3'd0) begin
                    res_last  = 1'b0;
                    res_final = 1'b0;
                end else begin
                    res_char  = tail_char(tail_pos, head.sum);
                    res_last  = (tail_pos == TP_LF);
                    res_final = (tail_pos == TP_LF);
                end
            end
        endcase
    end

    assign advance = !q_stat.empty && (!m_valid_reg || m_ready);
    assign pop     = advance && res_final;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg    <= 3'd0;
            m_valid_reg <= 1'b0;
        end else begin
            if (advance) begin
                step_reg    <= res_final ? 3'd0 : step_reg + 3'd1;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_char_reg       <= res_char;
            m_last_reg       <= res_last;
            m_line_valid_reg <= res_valid;
            m_kind_reg       <= res_kind;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_char       = m_char_reg;
    assign m_last       = m_last_reg;
    assign m_line_valid = m_line_valid_reg;
    assign m_kind       = m_kind_reg;

endmodule
